/* rtl/esu_pkg.sv */
// Package for the engine speed Euler step unit: widths, payload types,
// register codes and the saturating fixed-point helpers.
// No dependencies.
`default_nettype none

package esu_pkg;

  localparam int WORD_BITS  = 32;
  localparam int FRAC_BITS  = 16;
  localparam int SPD_BITS   = 31;
  localparam int PROD_BITS  = WORD_BITS + SPD_BITS;
  localparam int SHR_BITS   = PROD_BITS - FRAC_BITS;
  localparam int QUO_BITS   = 32;
  localparam int DIV_STEPS  = 4;
  localparam int DIV_STAGES = QUO_BITS / DIV_STEPS;
  localparam int APB_AW     = 4;
  localparam int APB_DW     = 32;

  typedef logic signed [WORD_BITS-1:0] word_t;
  typedef logic [WORD_BITS-1:0]        wmag_t;
  typedef logic [SPD_BITS-1:0]         spd_t;
  typedef logic [PROD_BITS-1:0]        prod_t;

  localparam word_t W_MAX       = {1'b0, {(WORD_BITS-1){1'b1}}};
  localparam word_t W_MIN       = {1'b1, {(WORD_BITS-1){1'b0}}};
  localparam wmag_t MAG_LIM_POS = {1'b0, {(WORD_BITS-1){1'b1}}};
  localparam wmag_t MAG_LIM_NEG = {1'b1, {(WORD_BITS-1){1'b0}}};
  localparam spd_t  OUT_MAX     = '1;

  typedef enum logic [1:0] {
    REG_FR_CONST,
    REG_FR_LIN,
    REG_FR_QUAD,
    REG_INERTIA
  } reg_idx_e;

  typedef struct packed {
    word_t friction_constant;
    word_t friction_linear;
    word_t friction_quadratic;
    spd_t  crank_inertia;
  } cfg_t;

  typedef struct packed {
    spd_t  current_speed;
    word_t combustion_torque;
    word_t load_torque;
    spd_t  time_step;
  } in_item_t;

  typedef struct packed {
    spd_t new_speed;
    logic saturated;
  } out_item_t;

  // Net torque as sign and magnitude, with what the divider side still needs.
  typedef struct packed {
    spd_t  speed;
    spd_t  dt;
    logic  hold;
    logic  neg;
    wmag_t mag;
  } net_item_t;

  function automatic wmag_t word_mag(input word_t a);
    wmag_t m;
    m = a;
    return a[WORD_BITS-1] ? (~m + 1'b1) : m;
  endfunction

  // Limit a magnitude to what a signed word of the given sign can hold.
  function automatic wmag_t mag_clip(input logic [SHR_BITS-1:0] m, input logic neg);
    logic [SHR_BITS-1:0] lim;
    lim = neg ? SHR_BITS'(MAG_LIM_NEG) : SHR_BITS'(MAG_LIM_POS);
    return (m > lim) ? lim[WORD_BITS-1:0] : m[WORD_BITS-1:0];
  endfunction

  function automatic word_t word_from_mag(input wmag_t m, input logic neg);
    wmag_t r;
    r = neg ? (~m + 1'b1) : m;
    return word_t'(r);
  endfunction

  function automatic word_t sat_add(input word_t a, input word_t b);
    logic [WORD_BITS:0] s;
    s = {a[WORD_BITS-1], a} + {b[WORD_BITS-1], b};
    if (s[WORD_BITS] != s[WORD_BITS-1]) begin
      return s[WORD_BITS] ? W_MIN : W_MAX;
    end
    return word_t'(s[WORD_BITS-1:0]);
  endfunction

  function automatic word_t sat_sub(input word_t a, input word_t b);
    logic [WORD_BITS:0] s;
    s = {a[WORD_BITS-1], a} - {b[WORD_BITS-1], b};
    if (s[WORD_BITS] != s[WORD_BITS-1]) begin
      return s[WORD_BITS] ? W_MIN : W_MAX;
    end
    return word_t'(s[WORD_BITS-1:0]);
  endfunction

endpackage

`default_nettype wire

/* rtl/esu_if.sv */
// Valid/ready stream interfaces for the input and result channels.
// Depends on esu_pkg for the payload types.
`default_nettype none

interface esu_in_if;
  logic             valid;
  logic             ready;
  esu_pkg::in_item_t item;

  modport source (output valid, output item, input ready);
  modport sink   (input valid, input item, output ready);
endinterface

interface esu_out_if;
  logic              valid;
  logic              ready;
  esu_pkg::out_item_t item;

  modport source (output valid, output item, input ready);
  modport sink   (input valid, input item, output ready);
endinterface

`default_nettype wire

/* rtl/esu_apb_regs.sv */
// APB register bank holding the friction coefficients and crank inertia.
// Depends on esu_pkg.
`default_nettype none

module esu_apb_regs (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [esu_pkg::APB_AW-1:0] paddr,
  input  logic [esu_pkg::APB_DW-1:0] pwdata,
  output logic [esu_pkg::APB_DW-1:0] prdata,
  output logic                       pready,
  output esu_pkg::cfg_t              cfg_o
);
  import esu_pkg::*;

  cfg_t     cfg_q, cfg_d;
  reg_idx_e idx;
  logic     wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = reg_idx_e'(paddr[APB_AW-1:2]);

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (idx)
        REG_FR_CONST: cfg_d.friction_constant  = word_t'(pwdata);
        REG_FR_LIN:   cfg_d.friction_linear    = word_t'(pwdata);
        REG_FR_QUAD:  cfg_d.friction_quadratic = word_t'(pwdata);
        REG_INERTIA:  cfg_d.crank_inertia      = pwdata[SPD_BITS-1:0];
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.friction_constant  <= '0;
      cfg_q.friction_linear    <= '0;
      cfg_q.friction_quadratic <= '0;
      cfg_q.crank_inertia      <= spd_t'(1) << FRAC_BITS;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  always_comb begin
    unique case (idx)
      REG_FR_CONST: prdata = cfg_q.friction_constant;
      REG_FR_LIN:   prdata = cfg_q.friction_linear;
      REG_FR_QUAD:  prdata = cfg_q.friction_quadratic;
      REG_INERTIA:  prdata = {1'b0, cfg_q.crank_inertia};
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

/* rtl/esu_torque.sv */
// Six-stage pipeline that forms friction and net torque from one item.
// Depends on esu_pkg.
`default_nettype none

module esu_torque (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  esu_pkg::cfg_t         cfg_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  esu_pkg::in_item_t     in_item_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output esu_pkg::net_item_t    out_item_o
);
  import esu_pkg::*;

  typedef struct packed {
    spd_t  speed;
    spd_t  dt;
    word_t comb;
    word_t load;
    logic  hold;
  } ctx_t;

  logic s1_v_q, s2_v_q, s3_v_q, s4_v_q, s5_v_q, s6_v_q;
  logic en1, en2, en3, en4, en5, en6;

  ctx_t  s1_ctx_q, s2_ctx_q, s3_ctx_q, s4_ctx_q, s5_ctx_q;
  ctx_t  s1_ctx_d;
  prod_t s1_plin_q, s1_pq1_q, s1_plin_d, s1_pq1_d;
  logic  s1_lin_neg_q, s1_q1_neg_q;
  word_t s2_lin_q, s2_lin_d;
  wmag_t s2_q1m_q, s2_q1m_d;
  logic  s2_q1_neg_q, s3_q1_neg_q;
  prod_t s3_pq_q, s3_pq_d;
  word_t s3_fa_q, s3_fa_d;
  word_t s4_fric_q, s4_fric_d;
  word_t s5_net1_q, s5_net1_d;
  word_t net_d;
  net_item_t s6_q, s6_d;

  // Each stage takes a new item when it is empty or its content moves on.
  assign en6        = !s6_v_q || out_ready_i;
  assign en5        = !s5_v_q || en6;
  assign en4        = !s4_v_q || en5;
  assign en3        = !s3_v_q || en4;
  assign en2        = !s2_v_q || en3;
  assign en1        = !s1_v_q || en2;
  assign in_ready_o = en1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
      s3_v_q <= 1'b0;
      s4_v_q <= 1'b0;
      s5_v_q <= 1'b0;
      s6_v_q <= 1'b0;
    end else begin
      if (en1) s1_v_q <= in_valid_i;
      if (en2) s2_v_q <= s1_v_q;
      if (en3) s3_v_q <= s2_v_q;
      if (en4) s4_v_q <= s3_v_q;
      if (en5) s5_v_q <= s4_v_q;
      if (en6) s6_v_q <= s5_v_q;
    end
  end

  always_comb begin
    s1_ctx_d.speed = in_item_i.current_speed;
    s1_ctx_d.dt    = in_item_i.time_step;
    s1_ctx_d.comb  = in_item_i.combustion_torque;
    s1_ctx_d.load  = in_item_i.load_torque;
    s1_ctx_d.hold  = (cfg_i.crank_inertia == '0) || (in_item_i.time_step == '0);
    s1_plin_d = prod_t'(word_mag(cfg_i.friction_linear)) * prod_t'(in_item_i.current_speed);
    s1_pq1_d  = prod_t'(word_mag(cfg_i.friction_quadratic)) * prod_t'(in_item_i.current_speed);
  end

  always_comb begin
    s2_lin_d = word_from_mag(mag_clip(s1_plin_q[PROD_BITS-1:FRAC_BITS], s1_lin_neg_q),
                             s1_lin_neg_q);
    s2_q1m_d = mag_clip(s1_pq1_q[PROD_BITS-1:FRAC_BITS], s1_q1_neg_q);
  end

  always_comb begin
    s3_pq_d = prod_t'(s2_q1m_q) * prod_t'(s2_ctx_q.speed);
    s3_fa_d = sat_add(cfg_i.friction_constant, s2_lin_q);
  end

  always_comb begin
    s4_fric_d = sat_add(s3_fa_q,
                        word_from_mag(mag_clip(s3_pq_q[PROD_BITS-1:FRAC_BITS], s3_q1_neg_q),
                                      s3_q1_neg_q));
    s5_net1_d = sat_sub(s4_ctx_q.comb, s4_fric_q);
    net_d     = sat_sub(s5_net1_q, s5_ctx_q.load);
  end

  always_comb begin
    s6_d.speed = s5_ctx_q.speed;
    s6_d.dt    = s5_ctx_q.dt;
    s6_d.hold  = s5_ctx_q.hold;
    s6_d.neg   = net_d[WORD_BITS-1];
    s6_d.mag   = word_mag(net_d);
  end

  always_ff @(posedge clk_i) begin
    if (en1 && in_valid_i) begin
      s1_ctx_q     <= s1_ctx_d;
      s1_plin_q    <= s1_plin_d;
      s1_pq1_q     <= s1_pq1_d;
      s1_lin_neg_q <= cfg_i.friction_linear[WORD_BITS-1];
      s1_q1_neg_q  <= cfg_i.friction_quadratic[WORD_BITS-1];
    end
    if (en2 && s1_v_q) begin
      s2_ctx_q    <= s1_ctx_q;
      s2_lin_q    <= s2_lin_d;
      s2_q1m_q    <= s2_q1m_d;
      s2_q1_neg_q <= s1_q1_neg_q;
    end
    if (en3 && s2_v_q) begin
      s3_ctx_q    <= s2_ctx_q;
      s3_pq_q     <= s3_pq_d;
      s3_fa_q     <= s3_fa_d;
      s3_q1_neg_q <= s2_q1_neg_q;
    end
    if (en4 && s3_v_q) begin
      s4_ctx_q  <= s3_ctx_q;
      s4_fric_q <= s4_fric_d;
    end
    if (en5 && s4_v_q) begin
      s5_ctx_q  <= s4_ctx_q;
      s5_net1_q <= s5_net1_d;
    end
    if (en6 && s5_v_q) begin
      s6_q <= s6_d;
    end
  end

  assign out_valid_o = s6_v_q;
  assign out_item_o  = s6_q;

endmodule

`default_nettype wire

/* rtl/esu_div.sv */
// Speed-change pipeline: |net| * time_step, a restoring divide by the inertia
// at four quotient bits per stage, then the clamped speed update.
// Depends on esu_pkg.
`default_nettype none

module esu_div (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  esu_pkg::spd_t        inertia_i,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  esu_pkg::net_item_t   in_item_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output esu_pkg::out_item_t   out_item_o
);
  import esu_pkg::*;

  typedef struct packed {
    spd_t                speed;
    logic                hold;
    logic                neg;
    logic                ovf;
    spd_t                rem;
    logic [QUO_BITS-1:0] num;
    logic [QUO_BITS-1:0] quo;
  } div_st_t;

  function automatic div_st_t div_step(input div_st_t s, input spd_t d);
    div_st_t             r;
    logic [SPD_BITS:0]   t;
    r = s;
    for (int i = 0; i < DIV_STEPS; i++) begin
      t     = {r.rem, r.num[QUO_BITS-1]};
      r.num = {r.num[QUO_BITS-2:0], 1'b0};
      if (t >= {1'b0, d}) begin
        t     = t - {1'b0, d};
        r.quo = {r.quo[QUO_BITS-2:0], 1'b1};
      end else begin
        r.quo = {r.quo[QUO_BITS-2:0], 1'b0};
      end
      r.rem = t[SPD_BITS-1:0];
    end
    return r;
  endfunction

  logic                prod_v_q, prod_en;
  prod_t               prod_q;
  spd_t                prod_speed_q;
  logic                prod_hold_q, prod_neg_q;
  div_st_t             init_d;
  div_st_t             d_q [DIV_STAGES+1];
  logic [DIV_STAGES:0] dv_q;
  logic [DIV_STAGES:0] den;
  logic                out_v_q, out_en;
  out_item_t           out_q, out_d;
  logic [QUO_BITS:0]   sum;
  div_st_t             last;

  assign out_en     = !out_v_q || out_ready_i;
  assign prod_en    = !prod_v_q || den[0];
  assign in_ready_o = prod_en;

  // Each divider stage takes a new item when it is empty or its content moves on.
  always_comb begin
    den[DIV_STAGES] = !dv_q[DIV_STAGES] || out_en;
    for (int k = DIV_STAGES - 1; k >= 0; k--) begin
      den[k] = !dv_q[k] || den[k+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_v_q <= 1'b0;
      dv_q     <= '0;
      out_v_q  <= 1'b0;
    end else begin
      if (prod_en) prod_v_q <= in_valid_i;
      if (den[0])  dv_q[0]  <= prod_v_q;
      for (int k = 1; k <= DIV_STAGES; k++) begin
        if (den[k]) dv_q[k] <= dv_q[k-1];
      end
      if (out_en)  out_v_q  <= dv_q[DIV_STAGES];
    end
  end

  always_ff @(posedge clk_i) begin
    if (prod_en && in_valid_i) begin
      prod_q       <= prod_t'(in_item_i.mag) * prod_t'(in_item_i.dt);
      prod_speed_q <= in_item_i.speed;
      prod_hold_q  <= in_item_i.hold;
      prod_neg_q   <= in_item_i.neg;
    end
  end

  // The quotient fits in QUO_BITS only when the part above them is below the divisor.
  always_comb begin
    init_d.speed = prod_speed_q;
    init_d.hold  = prod_hold_q;
    init_d.neg   = prod_neg_q;
    init_d.ovf   = prod_q[PROD_BITS-1:QUO_BITS] >= inertia_i;
    init_d.rem   = prod_q[PROD_BITS-1:QUO_BITS];
    init_d.num   = prod_q[QUO_BITS-1:0];
    init_d.quo   = '0;
  end

  always_ff @(posedge clk_i) begin
    if (den[0] && prod_v_q) begin
      d_q[0] <= init_d;
    end
    for (int k = 1; k <= DIV_STAGES; k++) begin
      if (den[k] && dv_q[k-1]) begin
        d_q[k] <= div_step(d_q[k-1], inertia_i);
      end
    end
  end

  assign last   = d_q[DIV_STAGES];
  assign sum    = {2'b00, last.speed} + {1'b0, last.quo};

  always_comb begin
    out_d.new_speed = last.speed;
    out_d.saturated = 1'b0;
    if (!last.hold) begin
      if (!last.neg) begin
        if (last.ovf || (sum > {2'b00, OUT_MAX})) begin
          out_d.new_speed = OUT_MAX;
          out_d.saturated = 1'b1;
        end else begin
          out_d.new_speed = sum[SPD_BITS-1:0];
        end
      end else if (last.ovf || (last.quo >= {1'b0, last.speed})) begin
        out_d.new_speed = '0;
      end else begin
        out_d.new_speed = last.speed - last.quo[SPD_BITS-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_en && dv_q[DIV_STAGES]) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_v_q;
  assign out_item_o  = out_q;

endmodule

`default_nettype wire

/* rtl/engine_speed_euler_step_unit.sv */
// Top level of the engine speed Euler step unit.
// Depends on esu_pkg, esu_if, esu_apb_regs, esu_torque and esu_div.
//
// Each input transaction yields exactly one result transaction, and a new
// transaction can be accepted in every cycle while the result side is ready.
// The result passes through the six-stage torque pipeline, one stage for the
// step product, one for the divider setup, the eight stages of the restoring
// divider that produce four quotient bits each, and the output register.
// Stalls on the result side fill empty stages first, so input is still taken
// while a result waits. The user must write registers through the APB port
// only while no transaction is in flight; the block does not enforce this.
`default_nettype none

module engine_speed_euler_step_unit (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  esu_in_if.sink                     req_i,
  esu_out_if.source                  rsp_o,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [esu_pkg::APB_AW-1:0] paddr,
  input  logic [esu_pkg::APB_DW-1:0] pwdata,
  output logic [esu_pkg::APB_DW-1:0] prdata,
  output logic                       pready
);
  import esu_pkg::*;

  cfg_t      cfg;
  logic      net_valid, net_ready;
  net_item_t net_item;

  esu_apb_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  esu_torque u_torque (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_valid_i  (req_i.valid),
    .in_ready_o  (req_i.ready),
    .in_item_i   (req_i.item),
    .out_valid_o (net_valid),
    .out_ready_i (net_ready),
    .out_item_o  (net_item)
  );

  esu_div u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .inertia_i   (cfg.crank_inertia),
    .in_valid_i  (net_valid),
    .in_ready_o  (net_ready),
    .in_item_i   (net_item),
    .out_valid_o (rsp_o.valid),
    .out_ready_i (rsp_o.ready),
    .out_item_o  (rsp_o.item)
  );

endmodule

`default_nettype wire

/* rtl/esu_checker.sv */
// Port-level checks for the engine speed Euler step unit, bound to the top.
// Depends on esu_pkg and engine_speed_euler_step_unit.
`default_nettype none

module esu_checker (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       rsp_valid_i,
  input  logic                       rsp_ready_i,
  input  esu_pkg::out_item_t         rsp_item_i,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [esu_pkg::APB_AW-1:0] paddr,
  input  logic [esu_pkg::APB_DW-1:0] pwdata,
  input  logic [esu_pkg::APB_DW-1:0] prdata,
  input  logic                       pready
);
  import esu_pkg::*;

  logic inr_wr, inr_rd;

  assign inr_wr = psel && penable && pwrite && pready &&
                  (paddr[APB_AW-1:2] == REG_INERTIA);
  assign inr_rd = psel && !pwrite && (paddr[APB_AW-1:2] == REG_INERTIA);

  // A stalled result transaction must not change or vanish.
  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i && $stable(rsp_item_i))
    else $error("result changed while stalled");

  // Only a clipped result may carry the saturation flag.
  a_sat_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && rsp_item_i.saturated |-> rsp_item_i.new_speed == OUT_MAX)
    else $error("saturated flag without upper limit");

  // The inertia register reads back the written value, top bit clear.
  a_inr_rb: assert property (@(posedge clk_i) disable iff (!rst_ni)
    inr_wr ##1 inr_rd |-> prdata == {1'b0, $past(pwdata[SPD_BITS-1:0])})
    else $error("inertia readback mismatch");

  a_pready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    psel && penable |-> pready)
    else $error("register access not completed");

endmodule

bind engine_speed_euler_step_unit esu_checker u_esu_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .rsp_valid_i (rsp_o.valid),
  .rsp_ready_i (rsp_o.ready),
  .rsp_item_i  (rsp_o.item),
  .psel        (psel),
  .penable     (penable),
  .pwrite      (pwrite),
  .paddr       (paddr),
  .pwdata      (pwdata),
  .prdata      (prdata),
  .pready      (pready)
);

`default_nettype wire

/* tb/engine_speed_euler_step_unit_tb.sv */
// Self-checking testbench for engine_speed_euler_step_unit: random and directed
// speed/torque transactions, friction and inertia programmed over APB.
// Depends on esu_pkg, esu_if and the RTL of the block.
`timescale 1ns / 1ps

module engine_speed_euler_step_unit_tb;
  import esu_pkg::*;

  localparam longint WORD_HI   = 64'sd2147483647;
  localparam longint WORD_LO   = -64'sd2147483648;
  localparam longint SPEED_TOP = 64'sd2147483647;

  // Keeps its own copy of the friction and inertia registers and the results
  // still owed by the block, oldest first.
  class speed_step_board;
    longint          fr_const;
    longint          fr_lin;
    longint          fr_quad;
    longint unsigned inertia;
    out_item_t       owed_q[$];
    int unsigned     errors;

    function new();
      fr_const = 0;
      fr_lin   = 0;
      fr_quad  = 0;
      inertia  = 65536;
      errors   = 0;
    endfunction

    function longint clamp_word(longint v);
      if (v > WORD_HI) begin
        return WORD_HI;
      end
      if (v < WORD_LO) begin
        return WORD_LO;
      end
      return v;
    endfunction

    function longint unsigned abs_val(longint v);
      return (v < 0) ? longint'(-v) : longint'(v);
    endfunction

    // Exact product, magnitude shifted down by the fraction bits, then
    // saturated into a signed word.
    function longint qmul(longint a, longint b);
      longint unsigned m;
      m = (abs_val(a) * abs_val(b)) >> FRAC_BITS;
      if ((a < 0) != (b < 0)) begin
        return (m > 64'd2147483648) ? WORD_LO : -longint'(m);
      end
      return (m > 64'd2147483647) ? WORD_HI : longint'(m);
    endfunction

    function void write_reg(reg_idx_e idx, logic [31:0] v);
      case (idx)
        REG_FR_CONST: fr_const = longint'($signed(v));
        REG_FR_LIN:   fr_lin   = longint'($signed(v));
        REG_FR_QUAD:  fr_quad  = longint'($signed(v));
        REG_INERTIA:  inertia  = v[30:0];
        default: ;
      endcase
    endfunction

    function out_item_t euler_step(in_item_t it);
      out_item_t       r;
      longint          speed;
      longint          comb;
      longint          load;
      longint          fric;
      longint          net;
      longint          delta;
      longint unsigned dt;
      longint unsigned quo;
      logic            sat;
      speed = longint'(it.current_speed);
      comb  = longint'($signed(it.combustion_torque));
      load  = longint'($signed(it.load_torque));
      dt    = it.time_step;
      sat   = 1'b0;
      if (inertia == 0 || dt == 0) begin
        r.new_speed = speed[30:0];
        r.saturated = 1'b0;
        return r;
      end
      fric = clamp_word(fr_const + qmul(fr_lin, speed));
      fric = clamp_word(fric + qmul(qmul(fr_quad, speed), speed));
      net  = clamp_word(clamp_word(comb - fric) - load);
      quo  = (abs_val(net) * dt) / inertia;
      if (net < 0) begin
        delta = (quo > 64'd2147483648) ? WORD_LO : -longint'(quo);
      end else if (quo > 64'd2147483647) begin
        delta = WORD_HI;
        sat   = 1'b1;
      end else begin
        delta = longint'(quo);
      end
      if (delta >= 0) begin
        if (sat || delta > SPEED_TOP - speed) begin
          speed = SPEED_TOP;
          sat   = 1'b1;
        end else begin
          speed = speed + delta;
        end
      end else begin
        speed = (delta < -speed) ? 0 : speed + delta;
        sat   = 1'b0;
      end
      r.new_speed = speed[30:0];
      r.saturated = sat;
      return r;
    endfunction

    function void note_input(in_item_t it);
      owed_q.push_back(euler_step(it));
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      if (owed_q.size() == 0) begin
        $error("result with nothing owed: new_speed %0d saturated %0d",
               got.new_speed, got.saturated);
        errors++;
        return;
      end
      want = owed_q.pop_front();
      if (got.new_speed !== want.new_speed) begin
        $error("new_speed: expected %0d, got %0d", want.new_speed, got.new_speed);
        errors++;
      end
      if (got.saturated !== want.saturated) begin
        $error("saturated: expected %0d, got %0d", want.saturated, got.saturated);
        errors++;
      end
    endfunction
  endclass

  logic                clk_i;
  logic                rst_ni;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [APB_AW-1:0]   paddr;
  logic [APB_DW-1:0]   pwdata;
  logic [APB_DW-1:0]   prdata;
  logic                pready;

  esu_in_if  req_if ();
  esu_out_if rsp_if ();

  speed_step_board sb = new();

  int unsigned idle_pct;
  int unsigned stall_pct;
  int unsigned hold_req;
  int unsigned hold_left;

  engine_speed_euler_step_unit u_top (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (req_if),
    .rsp_o   (rsp_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    #5_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  // Result side: check every accepted transaction, then pick next ready.
  // A long hold requested by the stimulus is counted down here.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (rsp_if.valid && rsp_if.ready) begin
        sb.check_result(rsp_if.item);
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_if.ready <= 1'b0;
      end else if (hold_req > 0) begin
        hold_left = hold_req;
        hold_req  = 0;
        rsp_if.ready <= 1'b0;
      end else begin
        rsp_if.ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  task automatic apb_write(input reg_idx_e idx, input logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= APB_AW'({idx, 2'b00});
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    sb.write_reg(idx, val);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic send_item(input in_item_t it);
    while ($urandom_range(99) < idle_pct) begin
      req_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_if.valid <= 1'b1;
    req_if.item  <= it;
    @(posedge clk_i);
    while (!req_if.ready) begin
      @(posedge clk_i);
    end
    sb.note_input(it);
  endtask

  // Stop offering and wait until every owed result has come back.
  task automatic drain();
    req_if.valid <= 1'b0;
    @(posedge clk_i);
    while (sb.owed_q.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (20) @(posedge clk_i);
  endtask

  function automatic in_item_t mk_item(logic [30:0] spd, logic [31:0] comb,
                                       logic [31:0] load, logic [30:0] dt);
    in_item_t it;
    it.current_speed     = spd;
    it.combustion_torque = comb;
    it.load_torque       = load;
    it.time_step         = dt;
    return it;
  endfunction

  function automatic logic [31:0] small_signed(input int unsigned span);
    logic [31:0] v;
    v = $urandom_range(span, 0);
    return $urandom_range(1) ? -v : v;
  endfunction

  // Mostly plausible engine values, with extremes and full-range noise mixed in.
  function automatic logic [31:0] pick_word();
    case ($urandom_range(15))
      0:       return 32'h0000_0000;
      1:       return 32'h7FFF_FFFF;
      2:       return 32'h8000_0000;
      3:       return 32'hFFFF_FFFF;
      4, 5, 6: return small_signed(1 << 22);
      7, 8, 9, 10: return small_signed(1 << 26);
      default: return $urandom();
    endcase
  endfunction

  function automatic in_item_t random_item();
    logic [31:0] spd;
    logic [31:0] dt;
    spd = pick_word();
    case ($urandom_range(15))
      0:       dt = 32'h0;
      1:       dt = 32'h7FFF_FFFF;
      2, 3, 4, 5, 6, 7, 8, 9: dt = $urandom_range(4096, 1);
      default: dt = $urandom();
    endcase
    return mk_item(spd[30:0], pick_word(), pick_word(), dt[30:0]);
  endfunction

  initial begin
    logic [31:0] fc;
    logic [31:0] fl;
    logic [31:0] fq;
    logic [31:0] inr;
    rst_ni        = 1'b0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    req_if.valid  = 1'b0;
    req_if.item   = '0;
    rsp_if.ready  = 1'b0;
    idle_pct      = 0;
    stall_pct     = 0;
    hold_req      = 0;
    hold_left     = 0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset settings: no friction, unit inertia, so the step is net * dt.
    send_item(mk_item(31'd0, 32'd0, 32'd0, 31'd65536));
    send_item(mk_item(31'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 31'h7FFF_FFFF));
    send_item(mk_item(31'd0, 32'h8000_0000, 32'h7FFF_FFFF, 31'h7FFF_FFFF));
    send_item(mk_item(31'h7FFF_FFFF, 32'h7FFF_FFFF, 32'd0, 31'd0));
    send_item(mk_item(31'h1234_5678, 32'h8000_0000, 32'h0, 31'd0));
    // Landing exactly on the top speed is not a clip; one more is.
    send_item(mk_item(31'h7FFF_FFFE, 32'd1, 32'd0, 31'd65536));
    send_item(mk_item(31'h7FFF_FFFE, 32'd2, 32'd0, 31'd65536));
    send_item(mk_item(31'h7FFF_FFFF, 32'd0, 32'd0, 31'd65536));
    // Speed falling exactly to zero, and past it.
    send_item(mk_item(31'd100, -32'sd100, 32'd0, 31'd65536));
    send_item(mk_item(31'd100, 32'd0, 32'd101, 31'd65536));
    send_item(mk_item(31'd5000, 32'h0001_0000, 32'hFFFF_0000, 31'd1));
    send_item(mk_item(31'h0A00_0000, 32'h0032_0000, 32'h0010_0000, 31'd655));
    send_item(mk_item(31'h2AAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA, 31'h5555_5555));
    send_item(mk_item(31'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555, 31'h2AAA_AAAA));
    send_item(mk_item(31'd1, 32'hFFFF_FFFF, 32'd0, 31'd65536));
    drain();

    // Zero inertia holds the speed whatever the torque.
    apb_write(REG_INERTIA, 32'h0);
    send_item(mk_item(31'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 31'h7FFF_FFFF));
    send_item(mk_item(31'd0, 32'h8000_0000, 32'h7FFF_FFFF, 31'd1));
    send_item(mk_item(31'h0123_4567, 32'h0100_0000, 32'h0, 31'd4096));
    drain();

    for (int p = 0; p < 8; p++) begin
      case (p)
        0: begin
          fc = 32'h0002_0000;
          fl = 32'h0000_0100;
          fq = 32'h0000_0001;
          inr = 32'h0000_8000;
        end
        1: begin
          fc = 32'h7FFF_FFFF;
          fl = 32'h7FFF_FFFF;
          fq = 32'h7FFF_FFFF;
          inr = 32'h7FFF_FFFF;
        end
        2: begin
          fc = 32'h8000_0000;
          fl = 32'h8000_0000;
          fq = 32'h8000_0000;
          inr = 32'h0000_0001;
        end
        4: begin
          fc = pick_word();
          fl = pick_word();
          fq = pick_word();
          // Only the low 31 bits hold the inertia, so this is zero.
          inr = 32'h8000_0000;
        end
        5: begin
          fc = $urandom_range(1 << 20, 0);
          fl = small_signed(1 << 12);
          fq = small_signed(1 << 4);
          inr = $urandom_range(1 << 20, 1);
        end
        default: begin
          fc = $urandom();
          fl = $urandom();
          fq = $urandom();
          inr = $urandom();
        end
      endcase
      apb_write(REG_FR_CONST, fc);
      apb_write(REG_FR_LIN, fl);
      apb_write(REG_FR_QUAD, fq);
      apb_write(REG_INERTIA, inr);
      case (p % 4)
        0: begin
          idle_pct  = 0;
          stall_pct = 0;
        end
        1: begin
          idle_pct  = 59;
          stall_pct = 0;
        end
        2: begin
          idle_pct  = 0;
          stall_pct = 59;
        end
        default: begin
          idle_pct  = 9;
          stall_pct = 9;
        end
      endcase
      for (int n = 0; n < 170; n++) begin
        // Block the result side for a while so the pipeline backs up.
        if (p == 0 && n == 40) begin
          hold_req = 400;
        end
        send_item(random_item());
      end
      drain();
    end

    if (sb.owed_q.size() != 0) begin
      $error("%0d results never arrived", sb.owed_q.size());
    end
    if (sb.errors == 0 && sb.owed_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
